/* design/hrt_pkg.sv */
// Shared widths, register codes and cell payload types for the hyperbolic loss kernel.
// Used by the square-root cell, the divider cell and the top level.
package hrt_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;

  // square-root row: 97-bit radicand padded to whole digit pairs, 49-bit root
  localparam int SQ_N_W    = 98;
  localparam int SQ_ROOT_W = 49;
  localparam int SQ_REM_W  = 51;
  localparam int SQ_STEPS  = SQ_ROOT_W;

  // divider row: one quotient bit per cell
  localparam int DIV_W     = 116;
  localparam int QB        = 36;

  // register codes (word index on the configuration port)
  localparam logic REG_ASYM  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_N_W-1:0]    n;
  } sq_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QB-1:0]    nlo;
    logic [QB-1:0]    q;
    logic [DIV_W-1:0] den;
  } dv_t;

endpackage

/* design/hrt_sqrt_cell.sv */
// One digit step of the integer square root row: take two radicand bits, emit one root bit.
// Depends on hrt_pkg.
module hrt_sqrt_cell import hrt_pkg::*; (
  input  logic clk,
  input  logic en,
  input  sq_t  din,
  output sq_t  dout
);

  logic [SQ_REM_W+1:0] rem2;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                ge;

  assign rem2  = {din.rem, din.n[SQ_N_W-1 -: 2]};
  assign trial = {{(SQ_REM_W - SQ_ROOT_W){1'b0}}, din.root, 2'b01};
  assign diff  = rem2 - trial;
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      dout.n <= din.n << 2;
      if (ge) begin
        dout.rem  <= diff[SQ_REM_W-1:0];
        dout.root <= {din.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        dout.rem  <= rem2[SQ_REM_W-1:0];
        dout.root <= {din.root[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* design/hrt_div_cell.sv */
// One restoring step of the divider row: shift in a dividend bit, emit one quotient bit.
// Depends on hrt_pkg.
module hrt_div_cell import hrt_pkg::*; (
  input  logic clk,
  input  logic en,
  input  dv_t  din,
  output dv_t  dout
);

  logic [DIV_W:0] rem2;
  logic [DIV_W:0] denx;
  logic [DIV_W:0] diff;
  logic           ge;

  assign rem2 = {din.rem, din.nlo[QB-1]};
  assign denx = {1'b0, din.den};
  assign diff = rem2 - denx;
  assign ge   = rem2 >= denx;

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
      dout.nlo <= din.nlo << 1;
      dout.q   <= {din.q[QB-2:0], ge};
      dout.den <= din.den;
    end
  end

endmodule

/* design/hyperbolic_rho_with_tail.sv */
// Top level of the hyperbolic robust-fit loss kernel with continuous tail.
// Depends on hrt_pkg, hrt_sqrt_cell and hrt_div_cell.
//
//  channel   | dir | payload (low bit first)                        | beat taken when
//  ----------+-----+------------------------------------------------+----------------------
//  s_*       | in  | tdata: x_in[31:0]                              | s_tvalid & s_tready
//  m_*       | out | tdata: rho_value, gradient, hessian, pad; user | m_tvalid & m_tready
//  APB       | in  | addr 0 asymptote, addr 4 knee_width            | psel&penable&pwrite
//
// One beat enters per clock while s_tready is high. A result passes through the
// 49-cell square-root row and the 36-cell divider rows behind it.
// Reset is synchronous; it clears the valid bits and the output/skid flags and loads the
// register defaults.
// When the output is held, the next result drops into a skid register and the whole
// pipeline stalls from the next cycle on; s_tready falls only while the skid register is full.
module hyperbolic_rho_with_tail import hrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] x_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] rho_value, [62:32] gradient, [94:63] hessian, [95] 0
  output logic        m_tuser,   // [0] in_tail
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // payload that travels beside the square-root row
  typedef struct packed {
    logic        tail;
    logic        dz;
    logic [48:0] ul2;
    logic [61:0] d2;
    logic [63:0] ur2;
    logic [95:0] ur3;
    logic [93:0] numt;
    logic [72:0] dent;
    logic [64:0] s;
  } sd_t;

  // flags that travel beside the divider rows
  typedef struct packed {
    logic        tail;
    logic        dz;
    logic        rz;
    logic [50:0] acc0;
    logic        ovfg;
    logic        ovfm;
  } fl_t;

  typedef struct packed {
    logic [31:0] rho;
    logic [30:0] grad;
    logic [31:0] hess;
    logic        tail;
  } res_t;

  // ---------------------------------------------------------------- configuration
  logic [31:0] asymptote;
  logic [30:0] knee_width;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      asymptote  <= '0;
      knee_width <= 31'd65536;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ASYM:  asymptote  <= pwdata;
        REG_SCALE: knee_width <= pwdata[30:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ASYM:  prdata = asymptote;
      REG_SCALE: prdata = {1'b0, knee_width};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic ov, sv, en;
  res_t od, sdat;
  logic lv;
  res_t ld;

  assign en       = !sv;
  assign s_tready = en;

  // ---------------------------------------------------------------- P0: input beat
  logic        v0;
  logic [31:0] x0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) x0 <= s_tdata;
  end

  // ---------------------------------------------------------------- P1: u, clamp, tail
  logic [32:0] u_c;
  logic [40:0] limr_c, dx41;
  logic        upos_c, tail_c;
  logic [32:0] ul_c, ul_neg_c;
  logic [31:0] ua_c, ur_c, dmr_c;

  always_comb begin
    u_c      = {x0[31], x0} - {asymptote[31], asymptote};
    dx41     = {10'b0, knee_width};
    // 1000*D = 1024*D - 16*D - 8*D
    limr_c   = (dx41 << 10) - (dx41 << 4) - (dx41 << 3);
    upos_c   = !u_c[32] && (u_c != '0);
    tail_c   = upos_c && ({8'b0, u_c} > limr_c);
    ul_c     = tail_c ? limr_c[32:0] : u_c;
    ul_neg_c = 33'd0 - ul_c;
    ua_c     = ul_c[32] ? ul_neg_c[31:0] : ul_c[31:0];
    ur_c     = upos_c ? u_c[31:0] : 32'd0;
    dmr_c    = tail_c ? (ur_c - limr_c[31:0]) : 32'd0;
  end

  logic        v1, tail1, dz1;
  logic [32:0] ul1;
  logic [31:0] ua1, ur1, dmr1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail1 <= tail_c;
      dz1   <= (knee_width == '0);
      ul1   <= ul_c;
      ua1   <= ua_c;
      ur1   <= ur_c;
      dmr1  <= dmr_c;
    end
  end

  // ---------------------------------------------------------------- P2: first products
  logic        v2, tail2, dz2;
  logic [32:0] ul2r;
  logic [31:0] ur2r;
  logic [61:0] d2_2;
  logic [63:0] ua2_2, ur2_2;
  logic [62:0] pdu2, pdm2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail2 <= tail1;
      dz2   <= dz1;
      ul2r  <= ul1;
      ur2r  <= ur1;
      d2_2  <= 62'(knee_width) * 62'(knee_width);
      ua2_2 <= 64'(ua1) * 64'(ua1);
      ur2_2 <= 64'(ur1) * 64'(ur1);
      pdu2  <= 63'(knee_width) * 63'(ur1);
      pdm2  <= 63'(knee_width) * 63'(dmr1);
    end
  end

  // ---------------------------------------------------------------- P3: second products
  logic        v3, tail3, dz3;
  logic [32:0] ul3;
  logic [61:0] d2_3;
  logic [63:0] ur2_3;
  logic [64:0] s3;
  logic [72:0] dent3;
  logic [62:0] nplo3, u3x;
  logic [61:0] nphi3;
  logic [63:0] u3lo3, u3hi3;
  logic [72:0] pdu73;

  assign pdu73 = {10'b0, pdu2};
  assign u3x   = '0;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail3 <= tail2;
      dz3   <= dz2;
      ul3   <= ul2r;
      d2_3  <= d2_2;
      ur2_3 <= ur2_2;
      s3    <= {1'b0, ua2_2} + {3'b0, d2_2};
      dent3 <= (pdu73 << 10) - (pdu73 << 4) - (pdu73 << 3);
      nplo3 <= 63'(knee_width) * 63'(pdm2[31:0]);
      nphi3 <= 62'(knee_width) * 62'(pdm2[62:32]);
      u3lo3 <= 64'(ur2_2[31:0]) * 64'(ur2r);
      u3hi3 <= 64'(ur2_2[63:32]) * 64'(ur2r);
    end
  end

  // ---------------------------------------------------------------- square-root row
  sq_t         sq [SQ_STEPS+1];
  sd_t         side [SQ_STEPS];
  logic [SQ_STEPS-1:0] vq;
  sd_t         side_in;

  always_comb begin
    sq[0].rem    = '0;
    sq[0].root   = '0;
    sq[0].n      = {1'b0, s3, 32'b0};
    side_in.tail = tail3;
    side_in.dz   = dz3;
    side_in.ul2  = {ul3, 16'b0};
    side_in.d2   = d2_3;
    side_in.ur2  = ur2_3;
    side_in.ur3  = {32'b0, u3lo3} + {u3hi3, 32'b0};
    side_in.numt = {31'b0, nplo3} + {nphi3, 32'b0} + {31'b0, u3x};
    side_in.dent = dent3;
    side_in.s    = s3;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    hrt_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq[k]),
      .dout (sq[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) vq <= '0;
    else if (en) vq <= {vq[SQ_STEPS-2:0], v3};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < SQ_STEPS; i++) side[i] <= side[i-1];
    end
  end

  // ---------------------------------------------------------------- Q1: s*r partials
  sd_t         sdq;
  logic [48:0] r_c;
  logic        q1v, tail_q1, dz_q1, rz_q1;
  logic [48:0] ul2_q1, r_q1;
  logic [61:0] d2_q1;
  logic [63:0] ur2_q1;
  logic [95:0] ur3_q1;
  logic [93:0] numt_q1;
  logic [72:0] dent_q1;
  logic [63:0] pr00;
  logic [48:0] pr01;
  logic [64:0] pr10;
  logic [49:0] pr11;

  assign sdq = side[SQ_STEPS-1];
  assign r_c = sq[SQ_STEPS].root;

  always_ff @(posedge clk) begin
    if (rst) q1v <= 1'b0;
    else if (en) q1v <= vq[SQ_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_q1 <= sdq.tail;
      dz_q1   <= sdq.dz;
      rz_q1   <= (r_c == '0);
      ul2_q1  <= sdq.ul2;
      r_q1    <= r_c;
      d2_q1   <= sdq.d2;
      ur2_q1  <= sdq.ur2;
      ur3_q1  <= sdq.ur3;
      numt_q1 <= sdq.numt;
      dent_q1 <= sdq.dent;
      pr00    <= 64'(sdq.s[31:0]) * 64'(r_c[31:0]);
      pr01    <= 49'(sdq.s[31:0]) * 49'(r_c[48:32]);
      pr10    <= 65'(sdq.s[64:32]) * 65'(r_c[31:0]);
      pr11    <= 50'(sdq.s[64:32]) * 50'(r_c[48:32]);
    end
  end

  // ---------------------------------------------------------------- Q2: operands
  logic [113:0]     sr_c;
  logic [49:0]      rmu_c;
  logic [50:0]      acc0_c;
  logic             q2v, tail_q2, dz_q2, rz_q2;
  logic [50:0]      acc0_q2;
  logic [DIV_W-1:0] gn2, gd2, mn2, md2, tn2, td2;

  always_comb begin
    sr_c   = 114'(pr00) + (114'(pr01) << 32) + (114'(pr10) << 32) + (114'(pr11) << 64);
    rmu_c  = {1'b0, r_q1} - {ul2_q1[48], ul2_q1};
    // a large negative u with a large scale reaches just past -2^49
    acc0_c = {{2{ul2_q1[48]}}, ul2_q1} - {2'b0, r_q1};
  end

  always_ff @(posedge clk) begin
    if (rst) q2v <= 1'b0;
    else if (en) q2v <= q1v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_q2 <= tail_q1;
      dz_q2   <= dz_q1;
      rz_q2   <= rz_q1;
      acc0_q2 <= acc0_c;
      gn2     <= tail_q1 ? DIV_W'({d2_q1, 28'b0}) : DIV_W'({rmu_c, 29'b0});
      gd2     <= tail_q1 ? DIV_W'(ur2_q1) : DIV_W'(r_q1);
      mn2     <= tail_q1 ? DIV_W'({d2_q1, 31'b0}) : DIV_W'({d2_q1, 47'b0});
      md2     <= tail_q1 ? DIV_W'(ur3_q1) : DIV_W'(sr_c);
      tn2     <= DIV_W'({numt_q1, 14'b0});
      td2     <= DIV_W'(dent_q1);
    end
  end

  // ---------------------------------------------------------------- Q3: half-up bias
  logic             q3v, tail_q3, dz_q3, rz_q3;
  logic [50:0]      acc0_q3;
  logic [DIV_W-1:0] gn3, gd3, mn3, md3, tn3, td3;

  always_ff @(posedge clk) begin
    if (rst) q3v <= 1'b0;
    else if (en) q3v <= q2v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_q3 <= tail_q2;
      dz_q3   <= dz_q2;
      rz_q3   <= rz_q2;
      acc0_q3 <= acc0_q2;
      gn3     <= gn2 + (gd2 >> 1);
      gd3     <= gd2;
      mn3     <= mn2 + (md2 >> 1);
      md3     <= md2;
      tn3     <= tn2;
      td3     <= td2;
    end
  end

  // ---------------------------------------------------------------- Q4: range check, load rows
  dv_t              dg [QB+1];
  dv_t              dm [QB+1];
  dv_t              dt [QB+1];
  fl_t              fl [QB];
  fl_t              fl_in;
  logic             q4v;
  logic [QB-1:0]    vd;

  always_ff @(posedge clk) begin
    if (rst) q4v <= 1'b0;
    else if (en) q4v <= q3v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg[0] <= '{rem: gn3 >> QB, nlo: gn3[QB-1:0], q: '0, den: gd3};
      dm[0] <= '{rem: mn3 >> QB, nlo: mn3[QB-1:0], q: '0, den: md3};
      dt[0] <= '{rem: tn3 >> QB, nlo: tn3[QB-1:0], q: '0, den: td3};
      fl_in <= '{tail: tail_q3, dz: dz_q3, rz: rz_q3, acc0: acc0_q3,
                 ovfg: (gn3 >> QB) >= gd3, ovfm: (mn3 >> QB) >= md3};
    end
  end

  // ---------------------------------------------------------------- divider rows
  for (genvar k = 0; k < QB; k++) begin : g_dv
    hrt_div_cell u_grad (.clk(clk), .en(en), .din(dg[k]), .dout(dg[k+1]));
    hrt_div_cell u_hess (.clk(clk), .en(en), .din(dm[k]), .dout(dm[k+1]));
    hrt_div_cell u_tail (.clk(clk), .en(en), .din(dt[k]), .dout(dt[k+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) vd <= '0;
    else if (en) vd <= {vd[QB-2:0], q4v};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= fl_in;
      for (int i = 1; i < QB; i++) fl[i] <= fl[i-1];
    end
  end

  // ---------------------------------------------------------------- final assembly
  fl_t         ff;
  logic [QB-1:0] t_c, gq, mq;
  logic [50:0] acc_c, accr_c, sh_c;
  logic [51:0] tot_c;
  logic        core0;
  res_t        res_c;

  always_comb begin
    ff     = fl[QB-1];
    gq     = dg[QB].q;
    mq     = dm[QB].q;
    // the tail term only exists past the clamp with a non-zero scale
    t_c    = (ff.tail && !ff.dz) ? dt[QB].q : '0;
    acc_c  = ff.acc0 + {14'b0, t_c, 1'b0};
    accr_c = acc_c + (51'd1 << FRAC_W);
    sh_c   = {{17{accr_c[50]}}, accr_c[50:17]};
    tot_c  = {{20{asymptote[31]}}, asymptote} + {sh_c[50], sh_c};
    core0  = !ff.tail && ff.rz;

    if (&tot_c[51:31] || ~|tot_c[51:31]) res_c.rho = tot_c[31:0];
    else if (tot_c[51]) res_c.rho = 32'h8000_0000;
    else res_c.rho = 32'h7FFF_FFFF;

    // zero root in the core: hold gradient at one half
    if (core0) res_c.grad = 31'h2000_0000;
    else if (ff.ovfg || gq > 36'h0_4000_0000) res_c.grad = 31'h4000_0000;
    else res_c.grad = gq[30:0];

    if (core0) res_c.hess = '0;
    else if (ff.ovfm || (mq[35:31] != '0)) res_c.hess = 32'h8000_0000;
    else res_c.hess = 32'd0 - mq[31:0];

    res_c.tail = ff.tail;
  end

  always_ff @(posedge clk) begin
    if (rst) lv <= 1'b0;
    else if (en) lv <= vd[QB-1];
  end

  always_ff @(posedge clk) begin
    if (en) ld <= res_c;
  end

  // ---------------------------------------------------------------- output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (en) begin
      if (ov && !m_tready) begin
        if (lv) sv <= 1'b1;
      end else begin
        ov <= lv;
      end
    end else if (m_tready) begin
      sv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ov && !m_tready) sdat <= ld;
      else od <= ld;
    end else if (m_tready) begin
      od <= sdat;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {1'b0, od.hess, od.grad, od.rho};
  assign m_tuser  = od.tail;

  // ---------------------------------------------------------------- checks
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid register full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
      $rose(sv) |-> $past(ov && !m_tready))
    else $error("skid register filled without a held output");

  a_grad_bound: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[62:32] <= 31'h4000_0000))
    else $error("gradient above one");

  a_hess_sign: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[94] || (m_tdata[94:63] == 32'd0)))
    else $error("positive hessian");

endmodule
